FILE: sv/hsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsc_pkg: shared types, constants and functions for the SECDED byte codec
// Codeword layout, status codes and the XOR-tree helpers used by the codec.
// ----------------------------------------------------------------------------
package hsc_pkg;

    localparam int DATA_W = 8;
    localparam int CW_W   = 13;
    localparam int SYN_W  = 4;
    localparam int STAT_W = 3;

    localparam logic [DATA_W-1:0] DOUBLE_ERR_BYTE = 8'h40;  // '@'
    localparam logic [SYN_W-1:0]  LAST_POS        = 4'd12;

    typedef enum logic {
        CMD_ENCODE = 1'b0,
        CMD_DECODE = 1'b1
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_CLEAN   = 3'd0,
        ST_SINGLE  = 3'd1,
        ST_PARITY  = 3'd2,
        ST_DOUBLE  = 3'd3,
        ST_INVALID = 3'd4
    } status_t;

    // XOR of the positions of all set bits among positions 1..12
    function automatic logic [SYN_W-1:0] syndrome_of(input logic [CW_W-1:0] w);
        logic [SYN_W-1:0] s;
        s = '0;
        for (int p = 1; p <= 12; p++)
        begin
            if (w[p-1])
            begin
                s = s ^ SYN_W'(p);
            end
        end
        return s;
    endfunction

    // Data bits 7..0 live at positions 3, 5, 6, 7, 9, 10, 11, 12
    function automatic logic [DATA_W-1:0] extract_byte(input logic [CW_W-1:0] w);
        return {w[2], w[4], w[5], w[6], w[8], w[9], w[10], w[11]};
    endfunction

    function automatic logic [CW_W-1:0] encode_byte(input logic [DATA_W-1:0] d);
        logic [CW_W-1:0]  w;
        logic [SYN_W-1:0] s;
        w = '0;
        w[2]  = d[7];
        w[4]  = d[6];
        w[5]  = d[5];
        w[6]  = d[4];
        w[8]  = d[3];
        w[9]  = d[2];
        w[10] = d[1];
        w[11] = d[0];
        s = syndrome_of(w);
        w[0]  = s[0];
        w[1]  = s[1];
        w[3]  = s[2];
        w[7]  = s[3];
        w[12] = ^w[11:0];
        return w;
    endfunction

endpackage

FILE: sv/hamming_secded_byte_codec_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming_secded_byte_codec_top: extended Hamming (13,8) SECDED encode/decode
// Encodes a byte into a 13-bit codeword or decodes and corrects a codeword.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle; busy is never raised, set by the input
// register feeding one XOR-tree stage into the result register.
// Reset: rst_n asynchronously clears the valid pipeline; no result is in
// flight after reset. The receiver cannot stall; done marks each result.
module hamming_secded_byte_codec_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        command,
    input  logic [hsc_pkg::DATA_W-1:0]  data_in,
    input  logic [hsc_pkg::CW_W-1:0]    code_in,
    output logic                        done,
    output logic [hsc_pkg::CW_W-1:0]    code_out,
    output logic [hsc_pkg::DATA_W-1:0]  data_out,
    output logic [hsc_pkg::STAT_W-1:0]  status
);
    import hsc_pkg::*;

    // Input register stage
    logic                valid_reg;
    cmd_t                cmd_reg;
    logic [DATA_W-1:0]   data_reg;
    logic [CW_W-1:0]     code_reg;

    // Result register stage
    logic                done_reg;
    logic [CW_W-1:0]     code_out_reg;
    logic [DATA_W-1:0]   data_out_reg;
    status_t             status_reg;

    // Combinational results
    logic [CW_W-1:0]     code_out_next;
    logic [DATA_W-1:0]   data_out_next;
    status_t             status_next;

    logic [SYN_W-1:0]    syn;
    logic                consistent;
    logic [CW_W-1:0]     flip_mask;
    logic [CW_W-1:0]     fixed_word;

    // The codec never holds off a beat: every cycle can take a new item.
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= start && !busy;
            done_reg  <= valid_reg;
        end
    end

    // Payload registers: capture on accept, advance on valid; no reset needed.
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg  <= cmd_t'(command);
            data_reg <= data_in;
            code_reg <= code_in;
        end
        if (valid_reg)
        begin
            code_out_reg <= code_out_next;
            data_out_reg <= data_out_next;
            status_reg   <= status_next;
        end
    end

    // Syndrome and overall parity check on the received word
    always_comb
    begin
        syn        = syndrome_of(code_reg);
        consistent = ((^code_reg[CW_W-2:0]) == code_reg[CW_W-1]);
        // One-hot flip for syndromes 1..12; 13..15 decode to no flip.
        flip_mask  = '0;
        for (int p = 1; p <= 12; p++)
        begin
            flip_mask[p-1] = (syn == SYN_W'(p));
        end
        fixed_word = code_reg ^ flip_mask;
    end

    // Result selection: order of checks decides the status
    always_comb
    begin
        code_out_next = code_reg;
        data_out_next = extract_byte(code_reg);
        status_next   = ST_CLEAN;
        if (cmd_reg == CMD_ENCODE)
        begin
            code_out_next = encode_byte(data_reg);
            data_out_next = '0;
            status_next   = ST_CLEAN;
        end
        else
        begin
            priority if (consistent && syn != '0)
            begin
                data_out_next = DOUBLE_ERR_BYTE;
                status_next   = ST_DOUBLE;
            end
            else if (consistent)
            begin
                status_next = ST_CLEAN;
            end
            else if (syn == '0)
            begin
                // Only the overall parity bit is off; leave it as received.
                status_next = ST_PARITY;
            end
            else if (syn <= LAST_POS)
            begin
                code_out_next = fixed_word;
                data_out_next = extract_byte(fixed_word);
                status_next   = ST_SINGLE;
            end
            else
            begin
                // Syndrome points past the codeword: pass the data through.
                status_next = ST_INVALID;
            end
        end
    end

    assign done     = done_reg;
    assign code_out = code_out_reg;
    assign data_out = data_out_reg;
    assign status   = status_reg;

    // Every accepted beat yields exactly one result, marked by done.
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("accepted beat produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg |=> !done)
        else $error("result strobe without an accepted beat");

    // An encoded word must itself decode clean.
    a_encode_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && cmd_reg == CMD_ENCODE) |=>
        (done && status == ST_CLEAN && data_out == '0 &&
         syndrome_of(code_out) == '0 && (^code_out) == 1'b0))
        else $error("encoded codeword is not a clean codeword");

    // A corrected word must come out with a zero syndrome.
    a_single_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_SINGLE) |-> (syndrome_of(code_out) == '0))
        else $error("single-error correction left a nonzero syndrome");

endmodule

FILE: sim/secded_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// secded_checker: result predictor and comparator for the SECDED byte codec
// Watches accepted command beats, predicts each result and compares it with
// the oldest prediction when done is seen.
// ----------------------------------------------------------------------------
module secded_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic                        command,
    input  logic [hsc_pkg::DATA_W-1:0]  data_in,
    input  logic [hsc_pkg::CW_W-1:0]    code_in,
    input  logic                        done,
    input  logic [hsc_pkg::CW_W-1:0]    code_out,
    input  logic [hsc_pkg::DATA_W-1:0]  data_out,
    input  logic [hsc_pkg::STAT_W-1:0]  status,
    output int                          mismatches,
    output int                          in_flight
);
    import hsc_pkg::*;

    typedef struct packed {
        logic [CW_W-1:0]   code;
        logic [DATA_W-1:0] data;
        status_t           stat;
    } secded_word_t;

    secded_word_t expected_words [$];
    secded_word_t want;

    // Hamming position (1-based) holding data bit 7-k
    function automatic int byte_slot(input int k);
        case (k)
            0:       return 3;
            1:       return 5;
            2:       return 6;
            3:       return 7;
            4:       return 9;
            5:       return 10;
            6:       return 11;
            default: return 12;
        endcase
    endfunction

    function automatic logic [SYN_W-1:0] check_bits(input logic [CW_W-1:0] w);
        logic [SYN_W-1:0] s;
        s = '0;
        for (int p = 1; p <= 12; p++)
        begin
            if (w[p-1])
                s = s ^ SYN_W'(p);
        end
        return s;
    endfunction

    function automatic logic [DATA_W-1:0] gather_byte(input logic [CW_W-1:0] w);
        logic [DATA_W-1:0] b;
        b = '0;
        for (int k = 0; k < DATA_W; k++)
            b = {b[DATA_W-2:0], w[byte_slot(k)-1]};
        return b;
    endfunction

    function automatic secded_word_t predict_secded(input cmd_t cmd,
                                                    input logic [DATA_W-1:0] d,
                                                    input logic [CW_W-1:0] c);
        secded_word_t     r;
        logic [CW_W-1:0]  w;
        logic [SYN_W-1:0] s;
        logic             even;
        r.data = '0;
        r.stat = ST_CLEAN;
        if (cmd == CMD_ENCODE)
        begin
            w = '0;
            for (int k = 0; k < DATA_W; k++)
                w[byte_slot(k)-1] = d[7-k];
            s = check_bits(w);
            w[0]  = s[0];
            w[1]  = s[1];
            w[3]  = s[2];
            w[7]  = s[3];
            w[12] = ^w[11:0];
            r.code = w;
        end
        else
        begin
            s = check_bits(c);
            even = ((^c[11:0]) == c[12]);
            r.code = c;
            if (even && s != '0)
            begin
                r.data = DOUBLE_ERR_BYTE;
                r.stat = ST_DOUBLE;
            end
            else if (even)
            begin
                r.data = gather_byte(c);
            end
            else if (s == '0)
            begin
                r.data = gather_byte(c);
                r.stat = ST_PARITY;
            end
            else if (s <= LAST_POS)
            begin
                r.code = c ^ (CW_W'(1) << (s - 1));
                r.data = gather_byte(r.code);
                r.stat = ST_SINGLE;
            end
            else
            begin
                r.data = gather_byte(c);
                r.stat = ST_INVALID;
            end
        end
        return r;
    endfunction

    // Push on every accepted beat, pop and compare on every done strobe
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_words.delete();
            mismatches = 0;
            in_flight  = 0;
        end
        else
        begin
            if (start && !busy)
                expected_words.push_back(
                    predict_secded(cmd_t'(command), data_in, code_in));
            if (done)
            begin
                if (expected_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing pending: ", $time,
                                 "code %h data %h status %0d",
                                 code_out, data_out, status);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (code_out !== want.code || data_out !== want.data ||
                        status !== want.stat)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: want code %h data %h status %0d, ", $time,
                                     want.code, want.data, want.stat,
                                     "got code %h data %h status %0d",
                                     code_out, data_out, status);
                    end
                end
            end
            in_flight = expected_words.size();
        end
    end

endmodule

FILE: sim/hamming_secded_byte_codec_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming_secded_byte_codec_top_tb: stimulus and verdict for the SECDED codec
// Drives directed and random encode/decode beats with injected bit flips and
// random idle gaps; a checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module hamming_secded_byte_codec_top_tb;
    import hsc_pkg::*;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              start    = 1'b0;
    logic              command  = 1'b0;
    logic [DATA_W-1:0] data_in  = '0;
    logic [CW_W-1:0]   code_in  = '0;
    logic              busy;
    logic              done;
    logic [CW_W-1:0]   code_out;
    logic [DATA_W-1:0] data_out;
    logic [STAT_W-1:0] status;

    int mismatches;
    int in_flight;

    // While set, the sender never inserts idle cycles
    bit steady = 1'b0;

    int n_directed = 0;
    int n_encode   = 0;
    int n_clean    = 0;
    int n_one      = 0;
    int n_two      = 0;
    int n_three    = 0;
    int n_noise    = 0;

    always #10 clk = ~clk;

    hamming_secded_byte_codec_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .command  (command),
        .data_in  (data_in),
        .code_in  (code_in),
        .done     (done),
        .code_out (code_out),
        .data_out (data_out),
        .status   (status)
    );

    secded_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .data_in    (data_in),
        .code_in    (code_in),
        .done       (done),
        .code_out   (code_out),
        .data_out   (data_out),
        .status     (status),
        .mismatches (mismatches),
        .in_flight  (in_flight)
    );

    // Turn any 12-bit pattern into a legal codeword: toggle the check bits at
    // positions 1, 2, 4 and 8 to cancel the syndrome, then set overall parity.
    function automatic logic [CW_W-1:0] legal_word(input logic [11:0] raw);
        logic [CW_W-1:0]  w;
        logic [SYN_W-1:0] s;
        w = {1'b0, raw};
        s = '0;
        for (int p = 1; p <= 12; p++)
        begin
            if (w[p-1])
                s = s ^ SYN_W'(p);
        end
        w[0]  = w[0] ^ s[0];
        w[1]  = w[1] ^ s[1];
        w[3]  = w[3] ^ s[2];
        w[7]  = w[7] ^ s[3];
        w[12] = ^w[11:0];
        return w;
    endfunction

    // Flip n distinct bits anywhere in the codeword, overall parity included
    function automatic logic [CW_W-1:0] flip_bits(input logic [CW_W-1:0] w, input int n);
        logic [CW_W-1:0] mask;
        int              b;
        int              cnt;
        mask = '0;
        cnt  = 0;
        while (cnt < n)
        begin
            b = $urandom_range(CW_W-1);
            if (!mask[b])
            begin
                mask[b] = 1'b1;
                cnt++;
            end
        end
        return w ^ mask;
    endfunction

    // Present one beat and hold it until the edge that accepts it. Start is
    // left high afterwards so back-to-back beats never drop it in between.
    task automatic send_beat(input cmd_t cmd, input logic [DATA_W-1:0] d,
                             input logic [CW_W-1:0] c);
        int gap;
        gap = (!steady && $urandom_range(99) < 7) ? 1 : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        command <= cmd;
        data_in <= d;
        code_in <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Hold the sender off until every pending result has come back
    task automatic drain_results();
        start <= 1'b0;
        @(negedge clk);
        while (in_flight != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Overall time limit, far above the slowest legal run
    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        logic [CW_W-1:0] w;
        int              pick;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed beats ----
        // Encode the byte extremes and alternating patterns; junk on code_in
        send_beat(CMD_ENCODE, 8'h00, 13'h1FFF);
        send_beat(CMD_ENCODE, 8'hFF, 13'h0000);
        send_beat(CMD_ENCODE, 8'h01, 13'h0AAA);
        send_beat(CMD_ENCODE, 8'h80, 13'h1555);
        send_beat(CMD_ENCODE, 8'hA5, CW_W'($urandom));
        send_beat(CMD_ENCODE, 8'h5A, CW_W'($urandom));
        // Clean decodes: all-zero word and a dense legal word
        send_beat(CMD_DECODE, 8'hFF, 13'h0000);
        w = legal_word(12'hFFF);
        send_beat(CMD_DECODE, 8'h00, w);
        // All ones: parity off, syndrome points at position 12
        send_beat(CMD_DECODE, 8'hFF, 13'h1FFF);
        // Single flips at the lowest and highest Hamming positions
        send_beat(CMD_DECODE, DATA_W'($urandom), w ^ 13'h0001);
        send_beat(CMD_DECODE, DATA_W'($urandom), w ^ 13'h0800);
        // Only the overall parity bit flipped
        send_beat(CMD_DECODE, DATA_W'($urandom), w ^ 13'h1000);
        // Double error: positions 3 and 5
        send_beat(CMD_DECODE, DATA_W'($urandom), w ^ 13'h0014);
        // Double error involving the parity bit: position 6 plus bit 12
        send_beat(CMD_DECODE, DATA_W'($urandom), w ^ 13'h1020);
        // Syndromes 13, 14, 15 with parity off: nothing may be flipped
        send_beat(CMD_DECODE, DATA_W'($urandom), w ^ 13'h0089);
        send_beat(CMD_DECODE, DATA_W'($urandom), w ^ 13'h008A);
        send_beat(CMD_DECODE, DATA_W'($urandom), w ^ 13'h1804);
        n_directed = 17;

        // Let the pipeline empty once before the random part
        drain_results();

        // ---- random beats ----
        for (int i = 0; i < 1880; i++)
        begin
            // Run a long stretch with no idle cycles at all
            steady = (i >= 700 && i < 1100);
            if (i == 1400)
                drain_results();
            pick = $urandom_range(99);
            if (pick < 30)
            begin
                n_encode++;
                send_beat(CMD_ENCODE, DATA_W'($urandom), CW_W'($urandom));
            end
            else
            begin
                w = legal_word(12'($urandom));
                if (pick < 48)
                begin
                    n_clean++;
                end
                else if (pick < 66)
                begin
                    n_one++;
                    w = flip_bits(w, 1);
                end
                else if (pick < 80)
                begin
                    n_two++;
                    w = flip_bits(w, 2);
                end
                else if (pick < 88)
                begin
                    n_three++;
                    w = flip_bits(w, 3);
                end
                else
                begin
                    n_noise++;
                    w = CW_W'($urandom);
                end
                send_beat(CMD_DECODE, DATA_W'($urandom), w);
            end
        end

        // ---- wind down ----
        start <= 1'b0;
        @(negedge clk);
        while (in_flight != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);

        $display("Covered %0d directed beats and %0d random encodes.", n_directed, n_encode);
        $display("Random decodes: %0d clean, %0d one-flip, %0d two-flip, ",
                 n_clean, n_one, n_two,
                 "%0d three-flip, %0d noise.", n_three, n_noise);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
